[rtl/core/ipf_pkg.sv]
package ipf_pkg;

  localparam int MAX_FIELD_WIDTH = 63;
  localparam int MAX_PRECISION   = 40;
  localparam int DIGIT_SLOTS     = 22;

  localparam int NUM_W = 64;
  localparam int LEN_W = 7;
  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int IDX_W = $clog2(DIGIT_SLOTS);
  localparam int BIT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_OCT  = 2'd2,
    OP_HEX  = 2'd3
  } op_t;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_A_UP  = 8'h41;
  localparam char_t CH_X_UP  = 8'h58;
  localparam char_t CH_A_LO  = 8'h61;
  localparam char_t CH_X_LO  = 8'h78;

  typedef struct packed {
    logic             start;
    op_t              op;
    logic [NUM_W-1:0] mag;
  } dig_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } dig_stat_t;

  // Region ends, in character positions, of each part of the field
  typedef struct packed {
    logic [LEN_W-1:0] b_lead;
    logic [LEN_W-1:0] b_sign;
    logic [LEN_W-1:0] b_prefix;
    logic [LEN_W-1:0] b_zeros;
    logic [LEN_W-1:0] b_digits;
    logic [LEN_W-1:0] n_chars;
    char_t            sign_char;
    logic             upper;
  } lay_t;

  function automatic char_t digit_char(input digit_t d, input logic upper);
    char_t c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (upper ? CH_A_UP : CH_A_LO) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[rtl/core/ipf_digit_unit.sv]
module ipf_digit_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ipf_pkg::dig_ctrl_t                ctrl,
  input  logic [ipf_pkg::IDX_W-1:0]         rd_idx,
  output ipf_pkg::digit_t                   rd_digit,
  output ipf_pkg::dig_stat_t                stat
);

  localparam int OCT_W = 3 * ipf_pkg::DIGIT_SLOTS;
  localparam int HEX_W = 4 * ipf_pkg::DIGIT_SLOTS;

  typedef enum logic [1:0] {
    D_IDLE,
    D_DABBLE,
    D_SCAN
  } dstate_t;

  dstate_t                         state_r, state_nxt;
  logic [ipf_pkg::NUM_W-1:0]       shift_r, shift_nxt;
  logic [ipf_pkg::BIT_W-1:0]       bit_r, bit_nxt;
  logic [ipf_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  ipf_pkg::digit_t                 dig_r   [ipf_pkg::DIGIT_SLOTS];
  ipf_pkg::digit_t                 dig_nxt [ipf_pkg::DIGIT_SLOTS];
  ipf_pkg::digit_t                 adj     [ipf_pkg::DIGIT_SLOTS];
  logic [ipf_pkg::DIGIT_SLOTS:0]   carry;
  logic [OCT_W-1:0]                oct_ext;
  logic [HEX_W-1:0]                hex_ext;
  logic [ipf_pkg::CNT_W-1:0]       cnt_m1;
  logic                            scan_step;

  assign oct_ext = OCT_W'(ctrl.mag);
  assign hex_ext = HEX_W'(ctrl.mag);

  // Shift-and-add-3 lanes, one per decimal digit
  always_comb begin
    carry[0] = shift_r[ipf_pkg::NUM_W-1];
    for (int i = 0; i < ipf_pkg::DIGIT_SLOTS; i++) begin
      adj[i]       = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
      carry[i + 1] = adj[i][3];
    end
  end

  assign cnt_m1    = cnt_r - 1'b1;
  assign scan_step = (cnt_r > ipf_pkg::CNT_W'(1)) &&
                     (dig_r[cnt_m1[ipf_pkg::IDX_W-1:0]] == 4'd0);

  assign stat.done  = (state_r == D_SCAN) && !scan_step;
  assign stat.count = cnt_r;

  assign rd_digit = ({1'b0, rd_idx} < (ipf_pkg::IDX_W + 1)'(ipf_pkg::DIGIT_SLOTS)) ?
                    dig_r[rd_idx] : 4'd0;

  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    case (state_r)
      D_IDLE: begin
        if (ctrl.start) begin
          case (ctrl.op)
            ipf_pkg::OP_OCT: begin
              for (int i = 0; i < ipf_pkg::DIGIT_SLOTS; i++) begin
                dig_nxt[i] = {1'b0, oct_ext[3*i +: 3]};
              end
              cnt_nxt   = ipf_pkg::CNT_W'(ipf_pkg::DIGIT_SLOTS);
              state_nxt = D_SCAN;
            end
            ipf_pkg::OP_HEX: begin
              for (int i = 0; i < ipf_pkg::DIGIT_SLOTS; i++) begin
                dig_nxt[i] = hex_ext[4*i +: 4];
              end
              cnt_nxt   = ipf_pkg::CNT_W'(ipf_pkg::DIGIT_SLOTS);
              state_nxt = D_SCAN;
            end
            default: begin
              for (int i = 0; i < ipf_pkg::DIGIT_SLOTS; i++) begin
                dig_nxt[i] = 4'd0;
              end
              shift_nxt = ctrl.mag;
              bit_nxt   = '0;
              state_nxt = D_DABBLE;
            end
          endcase
        end
      end
      D_DABBLE: begin
        for (int i = 0; i < ipf_pkg::DIGIT_SLOTS; i++) begin
          dig_nxt[i] = {adj[i][2:0], carry[i]};
        end
        shift_nxt = shift_r << 1;
        bit_nxt   = bit_r + 1'b1;
        if (bit_r == ipf_pkg::BIT_W'(ipf_pkg::NUM_W - 1)) begin
          cnt_nxt   = ipf_pkg::CNT_W'(ipf_pkg::DIGIT_SLOTS);
          state_nxt = D_SCAN;
        end
      end
      D_SCAN: begin
        // walk down past leading zero digits, keeping at least one
        if (scan_step) begin
          cnt_nxt = cnt_m1;
        end else begin
          state_nxt = D_IDLE;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      bit_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      cnt_r   <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    dig_r   <= dig_nxt;
  end

endmodule

[rtl/core/ipf_emit.sv]
module ipf_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  ipf_pkg::lay_t              lay,
  output logic                       busy,
  output logic [ipf_pkg::IDX_W-1:0]  rd_idx,
  input  ipf_pkg::digit_t            rd_digit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ipf_pkg::char_t             out_character,
  output logic                       out_char_valid,
  output logic                       out_last_char
);

  logic                        busy_r, busy_nxt;
  logic [ipf_pkg::LEN_W-1:0]   pos_r, pos_nxt;
  ipf_pkg::lay_t               lay_r, lay_nxt;
  logic                        oval_r, oval_nxt;
  ipf_pkg::char_t              char_r, char_nxt;
  logic                        cval_r, cval_nxt;
  logic                        last_r, last_nxt;

  logic                        slot_free;
  logic                        empty;
  logic                        is_last;
  logic [ipf_pkg::LEN_W-1:0]   didx;
  ipf_pkg::char_t              ch;

  assign slot_free = !oval_r || out_ready;
  assign empty     = (lay_r.n_chars == '0);
  assign is_last   = empty || (pos_r == lay_r.n_chars - 1'b1);
  assign didx      = lay_r.b_digits - 1'b1 - pos_r;
  assign rd_idx    = didx[ipf_pkg::IDX_W-1:0];

  always_comb begin
    if (pos_r < lay_r.b_lead) begin
      ch = ipf_pkg::CH_SPACE;
    end else if (pos_r < lay_r.b_sign) begin
      ch = lay_r.sign_char;
    end else if (pos_r < lay_r.b_prefix) begin
      if (pos_r == lay_r.b_sign) begin
        ch = ipf_pkg::CH_ZERO;
      end else begin
        ch = lay_r.upper ? ipf_pkg::CH_X_UP : ipf_pkg::CH_X_LO;
      end
    end else if (pos_r < lay_r.b_zeros) begin
      ch = ipf_pkg::CH_ZERO;
    end else if (pos_r < lay_r.b_digits) begin
      ch = ipf_pkg::digit_char(rd_digit, lay_r.upper);
    end else begin
      ch = ipf_pkg::CH_SPACE;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    lay_nxt  = lay_r;
    oval_nxt = oval_r;
    char_nxt = char_r;
    cval_nxt = cval_r;
    last_nxt = last_r;
    if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end
    if (busy_r && slot_free) begin
      oval_nxt = 1'b1;
      char_nxt = empty ? ipf_pkg::CH_NUL : ch;
      cval_nxt = !empty;
      last_nxt = is_last;
      pos_nxt  = pos_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
      lay_nxt  = lay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
      pos_r  <= pos_nxt;
    end
    lay_r  <= lay_nxt;
    char_r <= char_nxt;
    cval_r <= cval_nxt;
    last_r <= last_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = oval_r;
  assign out_character  = char_r;
  assign out_char_valid = cval_r;
  assign out_last_char  = last_r;

endmodule

[rtl/core/integer_printf_formatter_unit.sv]
// Integer printf conversion (d, u, o, x/X) to an ASCII character stream.
// Input channel (in_valid/in_ready): one transaction carries the value, the
// conversion kind, the flags, field width and precision. in_ready is high only
// while the unit is idle; one item is worked on at a time.
// Result channel (out_valid/out_ready): one transaction per character, with
// out_last_char on the final one. A conversion that gives no characters
// yields a single transaction with out_char_valid low and out_last_char high.
// Per item: decimal kinds run a shift-and-add-3 unit on the 64-bit magnitude;
// octal and hex load their digits at the accepting edge. A leading-zero scan
// then follows, the layout being set in its last cycle, and the text streams
// out at one character per cycle while the receiver keeps up (up to 63 chars).
// A stalled receiver holds the character in the output register; emission
// waits and nothing is lost. in_ready returns once the emitter's busy flag has
// cleared after the last character enters the output register and the
// control state is back to idle, so the next item overlaps its draining.
// Reset (rst_n, synchronous, active low) returns the unit to idle and drops
// any character not yet taken.
module integer_printf_formatter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [ipf_pkg::NUM_W-1:0]        in_number,
  input  logic                             in_left_justify,
  input  logic                             in_force_plus,
  input  logic                             in_space_sign,
  input  logic                             in_alternate_form,
  input  logic                             in_zero_pad,
  input  logic                             in_uppercase,
  input  logic [5:0]                       in_field_width,
  input  logic [5:0]                       in_digit_precision,
  input  logic                             in_precision_given,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_character,
  output logic                             out_char_valid,
  output logic                             out_last_char
);

  localparam int LW = ipf_pkg::LEN_W;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CONV,
    T_EMIT
  } tstate_t;

  tstate_t            state_r, state_nxt;
  ipf_pkg::op_t       op_r;
  logic               left_r, plus_r, space_r, alt_r, zero_r, upper_r, pgiven_r;
  logic               neg_r, magzero_r;
  logic [LW-1:0]      width_r, prec_r;

  logic               accept;
  logic               neg_in;
  ipf_pkg::dig_ctrl_t dctrl;
  ipf_pkg::dig_stat_t dstat;
  ipf_pkg::lay_t      lay;
  logic               load;
  logic               emit_busy;
  logic [ipf_pkg::IDX_W-1:0] rd_idx;
  ipf_pkg::digit_t    rd_digit;

  logic [LW-1:0]      w_in, p_in;
  logic [LW-1:0]      dcnt, zeros, plen, slen, total, pad, lead, zfill;
  logic               zf;
  ipf_pkg::char_t     sign_char;

  assign in_ready = (state_r == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign neg_in   = (ipf_pkg::op_t'(in_operation) == ipf_pkg::OP_SDEC) &&
                    in_number[ipf_pkg::NUM_W-1];

  assign dctrl.start = accept;
  assign dctrl.op    = ipf_pkg::op_t'(in_operation);
  assign dctrl.mag   = neg_in ? (~in_number + 1'b1) : in_number;

  assign w_in = LW'(in_field_width);
  assign p_in = LW'(in_digit_precision);

  // field layout, worked out once the digit count is known
  always_comb begin
    if (op_r == ipf_pkg::OP_SDEC) begin
      if (neg_r) begin
        sign_char = ipf_pkg::CH_MINUS;
      end else if (plus_r) begin
        sign_char = ipf_pkg::CH_PLUS;
      end else if (space_r) begin
        sign_char = ipf_pkg::CH_SPACE;
      end else begin
        sign_char = ipf_pkg::CH_NUL;
      end
    end else begin
      sign_char = ipf_pkg::CH_NUL;
    end
    slen = (sign_char != ipf_pkg::CH_NUL) ? LW'(1) : LW'(0);
    if (alt_r && !magzero_r && op_r == ipf_pkg::OP_HEX) begin
      plen = LW'(2);
    end else if (alt_r && !magzero_r && op_r == ipf_pkg::OP_OCT) begin
      plen = LW'(1);
    end else begin
      plen = LW'(0);
    end
    dcnt  = (pgiven_r && prec_r == '0 && magzero_r) ? LW'(0) : LW'(dstat.count);
    zeros = (pgiven_r && prec_r > dcnt) ? prec_r - dcnt : LW'(0);
    total = dcnt + zeros + plen + slen;
    pad   = (width_r > total) ? width_r - total : LW'(0);
    zf    = !left_r && zero_r && !pgiven_r;
    lead  = (!left_r && !zf) ? pad : LW'(0);
    zfill = zf ? pad : LW'(0);

    lay.b_lead    = lead;
    lay.b_sign    = lead + slen;
    lay.b_prefix  = lead + slen + plen;
    lay.b_zeros   = lead + slen + plen + zfill + zeros;
    lay.b_digits  = lead + slen + plen + zfill + zeros + dcnt;
    lay.n_chars   = total + pad;
    lay.sign_char = sign_char;
    lay.upper     = upper_r;
  end

  assign load = (state_r == T_CONV) && dstat.done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = T_CONV;
        end
      end
      T_CONV: begin
        if (dstat.done) begin
          state_nxt = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!emit_busy) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      op_r      <= ipf_pkg::op_t'(in_operation);
      left_r    <= in_left_justify;
      plus_r    <= in_force_plus;
      space_r   <= in_space_sign;
      alt_r     <= in_alternate_form;
      zero_r    <= in_zero_pad;
      upper_r   <= in_uppercase;
      pgiven_r  <= in_precision_given;
      neg_r     <= neg_in;
      magzero_r <= (in_number == '0);
      width_r   <= (w_in > LW'(ipf_pkg::MAX_FIELD_WIDTH)) ?
                   LW'(ipf_pkg::MAX_FIELD_WIDTH) : w_in;
      prec_r    <= (p_in > LW'(ipf_pkg::MAX_PRECISION)) ?
                   LW'(ipf_pkg::MAX_PRECISION) : p_in;
    end
  end

  ipf_digit_unit u_digit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (dctrl),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .stat     (dstat)
  );

  ipf_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .lay            (lay),
    .busy           (emit_busy),
    .rd_idx         (rd_idx),
    .rd_digit       (rd_digit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_char_valid (out_char_valid),
    .out_last_char  (out_last_char)
  );

endmodule
